// ===== design/ilp_pkg.sv =====
// shared types, character codes, error codes and the unit word table of the interval parser
`default_nettype none
package ilp_pkg;

   // result error codes
   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_CHAR   = 3'd1;
   localparam logic [2:0] ERR_NOUNIT = 3'd2;
   localparam logic [2:0] ERR_UNIT   = 3'd3;
   localparam logic [2:0] ERR_OVF    = 3'd4;

   // character codes
   localparam logic [7:0] CHAR_AT          = 8'h40;
   localparam logic [7:0] CHAR_SPACE       = 8'h20;
   localparam logic [7:0] CHAR_TAB         = 8'h09;
   localparam logic [7:0] CHAR_CR          = 8'h0D;
   localparam logic [7:0] CHAR_ZERO        = 8'h30;
   localparam logic [7:0] CHAR_NINE        = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A     = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z     = 8'h5A;
   localparam logic [7:0] CHAR_CASE_OFFSET = 8'h20;

   // sizes
   localparam int UNIT_CHARS_DEF = 12;
   localparam int QUEUE_DEPTH    = 2;
   localparam int UNIT_COUNT     = 25;
   localparam int UNIT_IDX_W     = 5;
   localparam int WORD_BYTES     = 12;
   localparam int NUM_W          = 31;
   localparam int PROD_W         = 63;

   // accumulator targets
   localparam logic [1:0] TGT_MONTHS = 2'd0;
   localparam logic [1:0] TGT_DAYS   = 2'd1;
   localparam logic [1:0] TGT_MICROS = 2'd2;

   typedef struct packed {
      logic [7:0] lc;
      logic       is_dig;
      logic       is_ws;
      logic       is_space;
      logic       is_at;
      logic       last;
   } char_type;

   typedef struct packed {
      logic                  add;
      logic [UNIT_IDX_W-1:0] unit_idx;
      logic [NUM_W-1:0]      number;
      logic                  is_final;
      logic [2:0]            err;
   } op_type;

   typedef struct packed {
      logic [8*WORD_BYTES-1:0] word;
      logic [3:0]              len;
      logic [1:0]              target;
      logic [31:0]             scale;
   } unit_def_type;

   function automatic unit_def_type unit_def(logic [UNIT_IDX_W-1:0] idx);
      unit_def_type u;
      u = '0;
      unique case (idx)
         5'd0:  begin u.word = "year";         u.len = 4'd4;  u.target = TGT_MONTHS; u.scale = 32'd12; end
         5'd1:  begin u.word = "years";        u.len = 4'd5;  u.target = TGT_MONTHS; u.scale = 32'd12; end
         5'd2:  begin u.word = "y";            u.len = 4'd1;  u.target = TGT_MONTHS; u.scale = 32'd12; end
         5'd3:  begin u.word = "month";        u.len = 4'd5;  u.target = TGT_MONTHS; u.scale = 32'd1; end
         5'd4:  begin u.word = "months";       u.len = 4'd6;  u.target = TGT_MONTHS; u.scale = 32'd1; end
         5'd5:  begin u.word = "mon";          u.len = 4'd3;  u.target = TGT_MONTHS; u.scale = 32'd1; end
         5'd6:  begin u.word = "day";          u.len = 4'd3;  u.target = TGT_DAYS;   u.scale = 32'd1; end
         5'd7:  begin u.word = "days";         u.len = 4'd4;  u.target = TGT_DAYS;   u.scale = 32'd1; end
         5'd8:  begin u.word = "d";            u.len = 4'd1;  u.target = TGT_DAYS;   u.scale = 32'd1; end
         5'd9:  begin u.word = "hour";         u.len = 4'd4;  u.target = TGT_MICROS;
                      u.scale = 32'd3600000000; end
         5'd10: begin u.word = "hours";        u.len = 4'd5;  u.target = TGT_MICROS;
                      u.scale = 32'd3600000000; end
         5'd11: begin u.word = "h";            u.len = 4'd1;  u.target = TGT_MICROS;
                      u.scale = 32'd3600000000; end
         5'd12: begin u.word = "minute";       u.len = 4'd6;  u.target = TGT_MICROS;
                      u.scale = 32'd60000000; end
         5'd13: begin u.word = "minutes";      u.len = 4'd7;  u.target = TGT_MICROS;
                      u.scale = 32'd60000000; end
         5'd14: begin u.word = "m";            u.len = 4'd1;  u.target = TGT_MICROS;
                      u.scale = 32'd60000000; end
         5'd15: begin u.word = "second";       u.len = 4'd6;  u.target = TGT_MICROS;
                      u.scale = 32'd1000000; end
         5'd16: begin u.word = "seconds";      u.len = 4'd7;  u.target = TGT_MICROS;
                      u.scale = 32'd1000000; end
         5'd17: begin u.word = "s";            u.len = 4'd1;  u.target = TGT_MICROS;
                      u.scale = 32'd1000000; end
         5'd18: begin u.word = "millisecond";  u.len = 4'd11; u.target = TGT_MICROS;
                      u.scale = 32'd1000; end
         5'd19: begin u.word = "milliseconds"; u.len = 4'd12; u.target = TGT_MICROS;
                      u.scale = 32'd1000; end
         5'd20: begin u.word = "ms";           u.len = 4'd2;  u.target = TGT_MICROS;
                      u.scale = 32'd1000; end
         5'd21: begin u.word = "msec";         u.len = 4'd4;  u.target = TGT_MICROS;
                      u.scale = 32'd1000; end
         5'd22: begin u.word = "microsecond";  u.len = 4'd11; u.target = TGT_MICROS;
                      u.scale = 32'd1; end
         5'd23: begin u.word = "microseconds"; u.len = 4'd12; u.target = TGT_MICROS;
                      u.scale = 32'd1; end
         5'd24: begin u.word = "us";           u.len = 4'd2;  u.target = TGT_MICROS;
                      u.scale = 32'd1; end
         default: u = '0;
      endcase
      return u;
   endfunction

   // true when unit word idx has character c at position pos (words are right-justified)
   function automatic logic unit_byte_ok(logic [UNIT_IDX_W-1:0] idx, logic [4:0] pos,
                                         logic [7:0] c);
      unit_def_type u;
      logic [4:0]   sh;
      logic [7:0]   b;
      u  = unit_def(idx);
      sh = {1'b0, u.len} - pos - 5'd1;
      b  = 8'(u.word >> {sh, 3'b000});
      return (pos < {1'b0, u.len}) && (b == c);
   endfunction

endpackage
`default_nettype wire

// ===== design/ilp_front.sv =====
// input side: character classification and a short item queue toward the parser
`default_nettype none
module ilp_front
   import ilp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_byte,
   input  wire logic       req_last_char,
   output logic            q_vld,
   output char_type        q_data,
   input  wire logic       q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   char_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   char_type             cls;
   logic                 push;

   always_comb begin
      cls.is_dig   = (req_char_byte >= CHAR_ZERO) && (req_char_byte <= CHAR_NINE);
      cls.is_space = (req_char_byte == CHAR_SPACE);
      cls.is_ws    = cls.is_space || ((req_char_byte >= CHAR_TAB) && (req_char_byte <= CHAR_CR));
      cls.is_at    = (req_char_byte == CHAR_AT);
      cls.lc       = ((req_char_byte >= CHAR_UPPER_A) && (req_char_byte <= CHAR_UPPER_Z)) ?
                     req_char_byte + CHAR_CASE_OFFSET : req_char_byte;
      cls.last     = req_last_char;
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_vld     = (count_ff != '0);
   assign q_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

// ===== design/ilp_parse.sv =====
// parser state machine: numbers, unit words and error detection, one item per cycle while the back end advances
`default_nettype none
module ilp_parse
   import ilp_pkg::*;
#(
   parameter int UNIT_CHARS = UNIT_CHARS_DEF
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_vld,
   input  wire char_type q_data,
   output logic          q_pop,
   input  wire logic     advance,
   output logic          op_vld,
   output op_type        op
);

   localparam int LEN_W = $clog2(UNIT_CHARS + 2);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_DIGITS = 2'd1;
   localparam logic [1:0] PH_GAP    = 2'd2;
   localparam logic [1:0] PH_UNIT   = 2'd3;

   logic [1:0]            phase_ff, phase_in;
   logic                  start_ff, start_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [UNIT_COUNT-1:0] mask_ff, mask_in;
   logic [2:0]            err_ff, err_in;
   logic                  op_vld_ff, op_vld_in;
   op_type                op_ff, op_in;

   char_type              c;
   logic [1:0]            ph1;
   logic [NUM_W-1:0]      num1;
   logic [LEN_W-1:0]      len1, base_len;
   logic [UNIT_COUNT-1:0] mask1, base_mask, ok_vec, hit_vec;
   logic [2:0]            err1, err2;
   logic                  push, entering, fin_a, fin_b, fin, hit;
   logic [NUM_W+3:0]      dec;
   logic [UNIT_IDX_W-1:0] idx;
   unit_def_type          ud;

   assign c     = q_data;
   assign q_pop = q_vld && advance;

   always_comb begin
      ph1      = phase_ff;
      num1     = num_ff;
      err1     = err_ff;
      push     = 1'b0;
      entering = 1'b0;
      fin_a    = 1'b0;
      dec      = ({4'b0, num_ff} << 3) + ({4'b0, num_ff} << 1) + (NUM_W+4)'(c.lc[3:0]);
      if (err_ff == ERR_NONE) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (start_ff && c.is_at) begin
                  ph1 = PH_IDLE;
               end else if (c.is_dig) begin
                  num1 = NUM_W'(c.lc[3:0]);
                  ph1  = PH_DIGITS;
               end else if (!c.is_ws) begin
                  err1 = ERR_CHAR;
               end
            end
            PH_DIGITS: begin
               if (c.is_dig) begin
                  if (|dec[NUM_W+3:NUM_W]) begin
                     err1 = ERR_OVF;
                  end else begin
                     num1 = dec[NUM_W-1:0];
                  end
               end else if (c.is_ws) begin
                  ph1 = PH_GAP;
               end else begin
                  ph1      = PH_UNIT;
                  push     = 1'b1;
                  entering = 1'b1;
               end
            end
            PH_GAP: begin
               if (!c.is_ws) begin
                  ph1      = PH_UNIT;
                  push     = 1'b1;
                  entering = 1'b1;
               end
            end
            PH_UNIT: begin
               if (c.is_space) begin
                  fin_a = 1'b1;
               end else begin
                  push = 1'b1;
               end
            end
            default: ph1 = PH_IDLE;
         endcase
      end
   end

   // unit word: incremental candidate mask plus a saturating length
   always_comb begin
      base_len  = entering ? '0 : len_ff;
      base_mask = entering ? '1 : mask_ff;
      for (int i = 0; i < UNIT_COUNT; i++) begin
         ok_vec[i] = unit_byte_ok(UNIT_IDX_W'(i), 5'(base_len), c.lc);
      end
      len1  = len_ff;
      mask1 = mask_ff;
      if (push) begin
         if (base_len < LEN_W'(UNIT_CHARS)) begin
            len1  = base_len + LEN_W'(1);
            mask1 = base_mask & ok_vec;
         end else begin
            len1  = LEN_W'(UNIT_CHARS + 1);
            mask1 = base_mask;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < UNIT_COUNT; i++) begin
         ud         = unit_def(UNIT_IDX_W'(i));
         hit_vec[i] = mask1[i] && (5'(len1) == {1'b0, ud.len});
      end
      idx = '0;
      for (int i = 0; i < UNIT_COUNT; i++) begin
         if (hit_vec[i]) begin
            idx = idx | UNIT_IDX_W'(i);
         end
      end
      hit   = (len1 <= LEN_W'(UNIT_CHARS)) && (|hit_vec);
      fin_b = c.last && (err1 == ERR_NONE) && (ph1 == PH_UNIT);
      fin   = fin_a || fin_b;
      err2  = err1;
      if (fin && !hit) begin
         err2 = ERR_UNIT;
      end else if (c.last && (err1 == ERR_NONE) && ((ph1 == PH_DIGITS) || (ph1 == PH_GAP))) begin
         err2 = ERR_NOUNIT;
      end
   end

   always_comb begin
      op_in.add      = fin && hit;
      op_in.unit_idx = idx;
      op_in.number   = num1;
      op_in.is_final = c.last;
      op_in.err      = err2;
      op_vld_in      = advance ? q_pop : op_vld_ff;
      phase_in       = phase_ff;
      start_in       = start_ff;
      num_in         = num_ff;
      len_in         = len_ff;
      mask_in        = mask_ff;
      err_in         = err_ff;
      if (q_pop) begin
         if (c.last) begin
            phase_in = PH_IDLE;
            start_in = 1'b1;
            num_in   = '0;
            len_in   = '0;
            err_in   = ERR_NONE;
         end else begin
            phase_in = fin ? PH_IDLE : ph1;
            start_in = 1'b0;
            num_in   = num1;
            len_in   = (ph1 == PH_DIGITS && phase_ff == PH_IDLE) ? '0 : len1;
            mask_in  = mask1;
            err_in   = err2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         start_ff  <= 1'b1;
         num_ff    <= '0;
         len_ff    <= '0;
         err_ff    <= ERR_NONE;
         op_vld_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         start_ff  <= start_in;
         num_ff    <= num_in;
         len_ff    <= len_in;
         err_ff    <= err_in;
         op_vld_ff <= op_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (advance) begin
         op_ff <= op_in;
      end
   end

   assign op_vld = op_vld_ff;
   assign op     = op_ff;

endmodule
`default_nettype wire

// ===== design/ilp_exec.sv =====
// back end: unit scale multiply, total accumulation and the result register
`default_nettype none
module ilp_exec
   import ilp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          op_vld,
   input  wire op_type        op,
   output logic               advance,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic signed [31:0] rsp_months_total,
   output logic signed [31:0] rsp_days_total,
   output logic signed [63:0] rsp_micros_total,
   output logic        [2:0]  rsp_error_code
);

   unit_def_type       ud;
   logic               mul_vld_ff, mul_vld_in;
   logic               mul_add_ff;
   logic [1:0]         mul_tgt_ff;
   logic [PROD_W-1:0]  mul_prod_ff, mul_prod_in;
   logic               mul_final_ff;
   logic [2:0]         mul_err_ff;
   logic [31:0]        months_acc_ff, months_acc_in, days_acc_ff, days_acc_in;
   logic [63:0]        micros_acc_ff, micros_acc_in;
   logic [31:0]        months_sum, days_sum;
   logic [63:0]        micros_sum;
   logic               out_vld_ff, out_vld_in;
   logic [31:0]        out_months_ff, out_days_ff;
   logic [63:0]        out_micros_ff;
   logic [2:0]         out_err_ff;
   logic               take;

   assign advance = !(mul_vld_ff && mul_final_ff && out_vld_ff && !rsp_ready);

   assign ud          = unit_def(op.unit_idx);
   assign mul_prod_in = PROD_W'(op.number) * PROD_W'(ud.scale);
   assign mul_vld_in  = advance ? op_vld : mul_vld_ff;

   always_comb begin
      months_sum = months_acc_ff;
      days_sum   = days_acc_ff;
      micros_sum = micros_acc_ff;
      if (mul_add_ff) begin
         case (mul_tgt_ff)
            TGT_MONTHS: months_sum = months_acc_ff + mul_prod_ff[31:0];
            TGT_DAYS:   days_sum   = days_acc_ff + mul_prod_ff[31:0];
            default:    micros_sum = micros_acc_ff + 64'(mul_prod_ff);
         endcase
      end
   end

   assign take = advance && mul_vld_ff;

   always_comb begin
      months_acc_in = months_acc_ff;
      days_acc_in   = days_acc_ff;
      micros_acc_in = micros_acc_ff;
      out_vld_in    = out_vld_ff && !rsp_ready;
      if (take) begin
         if (mul_final_ff) begin
            months_acc_in = '0;
            days_acc_in   = '0;
            micros_acc_in = '0;
            out_vld_in    = 1'b1;
         end else begin
            months_acc_in = months_sum;
            days_acc_in   = days_sum;
            micros_acc_in = micros_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff    <= 1'b0;
         months_acc_ff <= '0;
         days_acc_ff   <= '0;
         micros_acc_ff <= '0;
         out_vld_ff    <= 1'b0;
      end else begin
         mul_vld_ff    <= mul_vld_in;
         months_acc_ff <= months_acc_in;
         days_acc_ff   <= days_acc_in;
         micros_acc_ff <= micros_acc_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_add_ff   <= op.add;
         mul_tgt_ff   <= ud.target;
         mul_prod_ff  <= mul_prod_in;
         mul_final_ff <= op.is_final;
         mul_err_ff   <= op.err;
      end
      if (take && mul_final_ff) begin
         out_err_ff <= mul_err_ff;
         if (mul_err_ff == ERR_NONE) begin
            out_months_ff <= months_sum;
            out_days_ff   <= days_sum;
            out_micros_ff <= micros_sum;
         end else begin
            out_months_ff <= '0;
            out_days_ff   <= '0;
            out_micros_ff <= '0;
         end
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_months_total = $signed(out_months_ff);
   assign rsp_days_total   = $signed(out_days_ff);
   assign rsp_micros_total = $signed(out_micros_ff);
   assign rsp_error_code   = out_err_ff;

endmodule
`default_nettype wire

// ===== design/interval_literal_parser.sv =====
// interval literal parser top level: front queue, parser and accumulate back end
// throughput: one character item per cycle sustained; a result waiting on rsp_ready
//   stalls intake only once the next string's last character reaches the multiply register
// result path: rsp_valid rises once the last accepted character has passed the
//   queue register, parser op register, multiply register and result register
// reset: synchronous, clears the queue, parser state, totals and result valid
`default_nettype none
module interval_literal_parser
   import ilp_pkg::*;
#(
   parameter int UNIT_CHARS = UNIT_CHARS_DEF
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [7:0]    req_char_byte,
   input  wire logic          req_last_char,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic signed [31:0] rsp_months_total,
   output logic signed [31:0] rsp_days_total,
   output logic signed [63:0] rsp_micros_total,
   output logic        [2:0]  rsp_error_code
);

   // front to parser
   logic     q_vld;
   char_type q_data;
   logic     q_pop;

   // parser to back end
   logic     op_vld;
   op_type   op;
   logic     advance;

   // classify each character item and queue it
   ilp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_byte (req_char_byte),
      .req_last_char (req_last_char),
      .q_vld         (q_vld),
      .q_data        (q_data),
      .q_pop         (q_pop)
   );

   // walk the literal, one queued item per cycle while the back end advances
   ilp_parse #(
      .UNIT_CHARS (UNIT_CHARS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .q_vld   (q_vld),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .advance (advance),
      .op_vld  (op_vld),
      .op      (op)
   );

   // scale, accumulate, and hold the result until taken
   ilp_exec u_exec (
      .clock            (clock),
      .reset            (reset),
      .op_vld           (op_vld),
      .op               (op),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_months_total (rsp_months_total),
      .rsp_days_total   (rsp_days_total),
      .rsp_micros_total (rsp_micros_total),
      .rsp_error_code   (rsp_error_code)
   );

`ifndef SYNTHESIS
   // an errored result carries zero totals
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_NONE) |->
         (rsp_months_total == 0) && (rsp_days_total == 0) && (rsp_micros_total == 0))
      else $error("errored result has nonzero totals");

   // error code stays within the defined codes
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code <= ERR_OVF))
      else $error("undefined error code");

   // a full queue always offers an item to the parser
   a_full_has_item: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_vld)
      else $error("queue full but empty toward parser");
`endif

endmodule
`default_nettype wire
